// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/mi3_pkg.sv =====
// Types and constants of the 3x3 matrix inverse pipeline.
package mi3_pkg;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned CofW    = ProdW + 1;
  localparam int unsigned TermW   = ElemW + CofW;
  localparam int unsigned DetW    = 49;
  localparam int unsigned MagW    = 48;
  localparam int unsigned ThrW    = 48;
  localparam int unsigned InvW    = 32;
  localparam int unsigned NumShift = 28;
  localparam int unsigned NumW    = 32 + NumShift;
  localparam int unsigned QuoW    = 33;
  localparam int unsigned CmpW    = MagW + QuoW;
  localparam int unsigned NLane   = 9;
  localparam int unsigned InDataW  = NLane * ElemW;
  localparam int unsigned OutDataW = 344;
  localparam logic [ThrW-1:0] ThrReset = 48'd687195;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            ovf;
  } div_t;
endpackage

// ===== hdl/matrix_inverse_3x3_core.sv =====
// Top level of the 3x3 matrix inverse: adjugate, determinant and pipelined division.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid_i/tready_o   | tdata: nine Q4.12 entries
//  m_axis   | out       | m_axis_tvalid_o/tready_i   | tdata: inverse, det; tuser: singular
//  cfg      | in        | cfg_we_i                   | cfg_wdata_i: singular threshold
//
// One item enters per cycle unless stalled. Pipeline: five stages for products, cofactors,
// determinant terms, determinant sum and divider set-up, thirty-three restoring divider
// stages (one quotient bit each, nine lanes side by side) and one saturation stage that
// is the output register. All stages share one enable: the pipeline advances while the
// output is empty or taken, and stalls as a whole otherwise, keeping every item in place.
// Reset clears the valid bits and loads the threshold with its default.
module matrix_inverse_3x3_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0 ... in_r2_c2, 16 bits each
  input  logic [mi3_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // inv_r0_c0 ... inv_r2_c2 (32 bits each), determinant (49 bits), zero fill
  output logic [mi3_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // singular
  output logic                           m_axis_tuser_o,
  input  logic                           cfg_we_i,
  input  logic [mi3_pkg::ThrW-1:0]       cfg_wdata_i
);
  import mi3_pkg::*;

  localparam int unsigned NDiv = QuoW;
  localparam int unsigned NStg = 5 + NDiv + 1;

  logic [ThrW-1:0] thr_q;
  logic [NStg-1:0] v_q;
  logic            ce;

  logic signed [ElemW-1:0] m [3][3];
  logic signed [ProdW-1:0] pa_d [NLane];
  logic signed [ProdW-1:0] pb_d [NLane];
  logic signed [ProdW-1:0] pa_q [NLane];
  logic signed [ProdW-1:0] pb_q [NLane];
  logic signed [ElemW-1:0] r0a_q [3];
  logic signed [ElemW-1:0] r0b_q [3];
  logic signed [ElemW-1:0] r0c_q [3];
  logic signed [CofW-1:0]  cof2_q [NLane];
  logic signed [CofW-1:0]  cof3_q [NLane];
  logic signed [CofW-1:0]  cof4_q [NLane];
  logic signed [TermW-1:0] term_q [3];
  logic signed [TermW+1:0] dsum;
  logic signed [DetW-1:0]  det4_q;
  logic [MagW-1:0]         dmag4_q;
  logic                    sing4_q;

  div_t            dv_q [NDiv+1][NLane];
  logic [MagW-1:0] dmag_p [NDiv+1];
  logic [DetW-1:0] det_p [NDiv+1];
  logic            sing_p [NDiv+1];

  logic [InvW-1:0] inv_q [NLane];
  logic [DetW-1:0] deto_q;
  logic            singo_q;

  assign ce              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = ce;
  assign m_axis_tvalid_o = v_q[NStg-1];
  assign m_axis_tuser_o  = singo_q;

  always_comb begin
    for (int unsigned k = 0; k < OutDataW; k++) begin
      m_axis_tdata_o[k] = 1'b0;
    end
    for (int unsigned l = 0; l < NLane; l++) begin
      m_axis_tdata_o[l*InvW +: InvW] = inv_q[l];
    end
    m_axis_tdata_o[NLane*InvW +: DetW] = deto_q;
  end

  // Threshold register and valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      v_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (ce) begin
        v_q <= {v_q[NStg-2:0], s_axis_tvalid_i};
      end
    end
  end

  // Stage 1: the eighteen 2x2 minor products.
  always_comb begin
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) begin
        m[r][c] = s_axis_tdata_i[(r*3+c)*ElemW +: ElemW];
      end
    end
    pa_d[0] = m[1][1] * m[2][2];  pb_d[0] = m[2][1] * m[1][2];
    pa_d[1] = m[2][0] * m[1][2];  pb_d[1] = m[1][0] * m[2][2];
    pa_d[2] = m[1][0] * m[2][1];  pb_d[2] = m[2][0] * m[1][1];
    pa_d[3] = m[2][1] * m[0][2];  pb_d[3] = m[0][1] * m[2][2];
    pa_d[4] = m[0][0] * m[2][2];  pb_d[4] = m[2][0] * m[0][2];
    pa_d[5] = m[2][0] * m[0][1];  pb_d[5] = m[0][0] * m[2][1];
    pa_d[6] = m[0][1] * m[1][2];  pb_d[6] = m[1][1] * m[0][2];
    pa_d[7] = m[1][0] * m[0][2];  pb_d[7] = m[0][0] * m[1][2];
    pa_d[8] = m[0][0] * m[1][1];  pb_d[8] = m[1][0] * m[0][1];
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int unsigned l = 0; l < NLane; l++) begin
        pa_q[l]   <= pa_d[l];
        pb_q[l]   <= pb_d[l];
        // Stage 2: cofactors. Stage 3 and 4 carry them along.
        cof2_q[l] <= CofW'(pa_q[l]) - CofW'(pb_q[l]);
        cof3_q[l] <= cof2_q[l];
        cof4_q[l] <= cof3_q[l];
      end
      for (int unsigned c = 0; c < 3; c++) begin
        r0a_q[c]  <= m[0][c];
        r0b_q[c]  <= r0a_q[c];
        // Stage 3: expansion terms along row 0.
        term_q[c] <= r0b_q[c] * cof2_q[c];
      end
      // Stage 4: determinant, magnitude and singular test.
      det4_q  <= DetW'(dsum);
      dmag4_q <= dsum[TermW+1] ? MagW'(-dsum) : MagW'(dsum);
      sing4_q <= (dsum[TermW+1] ? MagW'(-dsum) : MagW'(dsum)) <= thr_q;
    end
  end

  assign dsum = (TermW+2)'(term_q[0]) + (TermW+2)'(term_q[1]) + (TermW+2)'(term_q[2]);

  // Stage 5: divider set-up. Lane i*3+j takes the transposed cofactor c[j][i].
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int unsigned i = 0; i < 3; i++) begin
        for (int unsigned j = 0; j < 3; j++) begin
          logic [31:0]     cmag;
          logic [NumW-1:0] num;
          cmag = cof4_q[j*3+i][CofW-1] ? 32'(-cof4_q[j*3+i]) : 32'(cof4_q[j*3+i]);
          num  = {cmag, NumShift'(0)};
          dv_q[0][i*3+j].rem <= num;
          dv_q[0][i*3+j].quo <= '0;
          dv_q[0][i*3+j].neg <= cof4_q[j*3+i][CofW-1] ^ det4_q[DetW-1];
          dv_q[0][i*3+j].ovf <= CmpW'(num) >= {dmag4_q, QuoW'(0)};
        end
      end
      dmag_p[0] <= dmag4_q;
      det_p[0]  <= det4_q;
      sing_p[0] <= sing4_q;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  for (genvar g = 0; g < NDiv; g++) begin : g_div
    localparam int unsigned K = NDiv - 1 - g;
    always_ff @(posedge clk_i) begin
      if (ce) begin
        for (int unsigned l = 0; l < NLane; l++) begin
          logic [CmpW-1:0] dsh;
          logic [CmpW-1:0] rx;
          dsh = CmpW'(dmag_p[g]) << K;
          rx  = CmpW'(dv_q[g][l].rem);
          dv_q[g+1][l].neg <= dv_q[g][l].neg;
          dv_q[g+1][l].ovf <= dv_q[g][l].ovf;
          if (rx >= dsh) begin
            dv_q[g+1][l].rem    <= NumW'(rx - dsh);
            dv_q[g+1][l].quo    <= dv_q[g][l].quo | (QuoW'(1) << K);
          end else begin
            dv_q[g+1][l].rem    <= dv_q[g][l].rem;
            dv_q[g+1][l].quo    <= dv_q[g][l].quo;
          end
        end
        dmag_p[g+1] <= dmag_p[g];
        det_p[g+1]  <= det_p[g];
        sing_p[g+1] <= sing_p[g];
      end
    end
  end

  // Output stage: apply sign, saturate, zero the inverse of a singular matrix.
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int unsigned l = 0; l < NLane; l++) begin
        logic [QuoW-1:0] qv;
        qv = dv_q[NDiv][l].quo;
        if (sing_p[NDiv]) begin
          inv_q[l] <= '0;
        end else if (dv_q[NDiv][l].neg) begin
          if (dv_q[NDiv][l].ovf || qv > (QuoW'(1) << (InvW-1))) begin
            inv_q[l] <= {1'b1, (InvW-1)'(0)};
          end else begin
            inv_q[l] <= InvW'(-qv);
          end
        end else begin
          if (dv_q[NDiv][l].ovf || qv[QuoW-1] || qv[InvW-1]) begin
            inv_q[l] <= {1'b0, {(InvW-1){1'b1}}};
          end else begin
            inv_q[l] <= qv[InvW-1:0];
          end
        end
      end
      deto_q  <= det_p[NDiv];
      singo_q <= sing_p[NDiv];
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_follows_output, 1'b1,
               s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
  `ASSERT_IMPL(a_singular_zeroes_inverse, m_axis_tvalid_o && m_axis_tuser_o,
               m_axis_tdata_o[NLane*InvW-1:0] == '0)
  `ASSERT_NEXT(a_accept_enters_pipe, s_axis_tvalid_i && s_axis_tready_o, v_q[0])
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the 3x3 matrix inverse core: random and directed matrices against a predictor.
module tb_top;
  import mi3_pkg::*;

  localparam int unsigned Latency = 39;

  typedef struct {
    logic [OutDataW-1:0] data;
    logic                sing;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;

  logic [ThrW-1:0] thr_model;
  inverse_t expected_q[$];
  int mismatches = 0;
  bit rx_stall_on = 1'b1;

  always #1 clk_i = ~clk_i;

  matrix_inverse_3x3_core dut (.*);

  // Signed quotient truncated toward zero, saturated to 32 bits.
  function automatic logic [InvW-1:0] sat_quotient(longint cof, longint det);
    longint q;
    q = (cof * (64'sd1 <<< 28)) / det;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[InvW-1:0];
  endfunction

  function automatic inverse_t invert_matrix(logic [InDataW-1:0] d);
    longint m [3][3];
    longint c [3][3];
    longint det, mag;
    inverse_t r;
    bit sing;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = longint'($signed(d[(i*3+j)*ElemW +: ElemW]));
    c[0][0] = m[1][1]*m[2][2] - m[2][1]*m[1][2];
    c[0][1] = -(m[1][0]*m[2][2] - m[2][0]*m[1][2]);
    c[0][2] = m[1][0]*m[2][1] - m[2][0]*m[1][1];
    c[1][0] = -(m[0][1]*m[2][2] - m[2][1]*m[0][2]);
    c[1][1] = m[0][0]*m[2][2] - m[2][0]*m[0][2];
    c[1][2] = -(m[0][0]*m[2][1] - m[2][0]*m[0][1]);
    c[2][0] = m[0][1]*m[1][2] - m[1][1]*m[0][2];
    c[2][1] = -(m[0][0]*m[1][2] - m[1][0]*m[0][2]);
    c[2][2] = m[0][0]*m[1][1] - m[1][0]*m[0][1];
    det = m[0][0]*c[0][0] + m[0][1]*c[0][1] + m[0][2]*c[0][2];
    mag = (det < 0) ? -det : det;
    sing = (mag <= longint'({16'd0, thr_model}));
    r.data = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r.data[(i*3+j)*InvW +: InvW] = sing ? '0 : sat_quotient(c[j][i], det);
    r.data[9*InvW +: DetW] = det[DetW-1:0];
    r.sing = sing;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Send one matrix; record its prediction when the item is taken.
  task automatic send_matrix(logic [InDataW-1:0] d, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(invert_matrix(d));
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Wait until the pipeline is drained, then write the threshold.
  task automatic write_threshold(logic [ThrW-1:0] v);
    wait (expected_q.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_model = v;
  endtask

  function automatic logic [InDataW-1:0] pack_rows(logic [15:0] e [9]);
    logic [InDataW-1:0] d;
    for (int k = 0; k < 9; k++) d[k*ElemW +: ElemW] = e[k];
    return d;
  endfunction

  function automatic logic [InDataW-1:0] rand_matrix();
    logic [InDataW-1:0] d;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (mode)
        0: d[k*ElemW +: ElemW] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        1, 2: d[k*ElemW +: ElemW] = 16'($signed($urandom_range(0, 64)) - 32);
        default: d[k*ElemW +: ElemW] = 16'($urandom());
      endcase
    end
    // Make some rows dependent to reach the singular path.
    if (mode == 3) d[6*ElemW +: 3*ElemW] = d[3*ElemW +: 3*ElemW];
    if (mode == 4) d[0 +: 3*ElemW] = '0;
    return d;
  endfunction

  task automatic test_directed();
    logic [15:0] e [9];
    e = '{16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000};
    send_matrix(pack_rows(e), 0);
    e = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
    send_matrix(pack_rows(e), 0);
    e = '{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF};
    send_matrix(pack_rows(e), 0);
    e = '{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
    send_matrix(pack_rows(e), 0);
    e = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
          16'h8000};
    send_matrix(pack_rows(e), 0);
    e = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF};
    send_matrix(pack_rows(e), 0);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(pack_rows(e), 0);
    e = '{16'h0010, 3, 0, 0, 16'h0010, 0, 0, 0, 16'h0010};
    send_matrix(pack_rows(e), 0);
    e = '{0, 16'h1000, 0, 16'h1000, 0, 0, 0, 0, 16'hF000};
    send_matrix(pack_rows(e), 0);
    e = '{16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC,
          16'h8001};
    send_matrix(pack_rows(e), 0);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_matrix(rand_matrix(), $urandom_range(0, 3) != 0);
  endtask

  task automatic test_thresholds();
    write_threshold('0);
    test_random(60);
    write_threshold('1);
    test_random(40);
    write_threshold(48'd1 << 20);
    test_random(60);
    write_threshold(48'($urandom()) << $urandom_range(0, 16));
    test_random(60);
    write_threshold(ThrReset);
    test_random(40);
  endtask

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    if (!rx_stall_on) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 9) < 7);
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      inverse_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: tdata=%h", m_axis_tdata_o);
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_axis_tdata_o[k*InvW +: InvW] !== want.data[k*InvW +: InvW]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Inverse entry %0d: expected %h, got %h", k,
                       want.data[k*InvW +: InvW], m_axis_tdata_o[k*InvW +: InvW]);
          end
        if (m_axis_tdata_o[9*InvW +: DetW] !== want.data[9*InvW +: DetW]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Determinant: expected %h, got %h", want.data[9*InvW +: DetW],
                     m_axis_tdata_o[9*InvW +: DetW]);
        end
        if (m_axis_tdata_o[OutDataW-1:9*InvW+DetW] !== '0) begin
          mismatches++;
          if (mismatches <= 10) $display("Fill bits not zero");
        end
        if (m_axis_tuser_o !== want.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Singular flag: expected %b, got %b", want.sing, m_axis_tuser_o);
        end
      end
    end
  end

  initial begin
    thr_model = ThrReset;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(220);
    rx_stall_on = 1'b0;
    test_random(60);
    rx_stall_on = 1'b1;
    test_thresholds();
    wait (expected_q.size() == 0);
    repeat (Latency + 10) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule
